// File: src/greedy_lz_match_encoder_assert.svh
// assertion macros for the greedy lz match encoder
`ifndef GREEDY_LZ_MATCH_ENCODER_ASSERT_SVH
`define GREEDY_LZ_MATCH_ENCODER_ASSERT_SVH

// implication checked on every clock edge outside reset
`define GLZ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication checked on the clock edge after the antecedent
`define GLZ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: src/glzme_pkg.sv
// ---------------------------------------------------------------------------
// glzme_pkg
// shared types and constants of the greedy lz match encoder
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package glzme_pkg;

    localparam int MaxLen = 1024;
    localparam int AddrW  = $clog2(MaxLen);
    localparam int PosW   = AddrW + 1;
    localparam int OutPosW = 10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_EXT_WAIT,
        ST_EMIT,
        ST_CLEAR
    } glz_state_t;

    // controller to datapath
    typedef struct packed {
        logic       take;        // latch input beat
        logic       scan_start;  // begin search at address zero
        logic       scan_step;   // advance search address
        logic       ext_read;    // read byte after run end
        logic       do_ext_hit;  // store byte and extend run
        logic       do_literal;  // store byte, emit literal
        logic       do_open;     // store byte, open run at found address
        logic       do_close;    // queue closing token of the open run
        logic       do_ovf;      // queue overflow literal
        logic       do_eos;      // return stream state to reset
        logic       out_pop;     // one queued token accepted downstream
    } glz_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       at_cap;      // position at capacity
        logic       match_open;
        logic       ext_ok;      // next address lies in history
        logic       ext_hit;     // registered read matches byte
        logic       scan_hit;    // registered scan read matches byte
        logic       scan_end;    // scan address reached position
        logic       budget_last; // extension would use up budget
        logic       open_zero;   // opening at position one
        logic       eos;
        logic       q_empty;
    } glz_stat_t;

    typedef struct packed {
        logic               last_token;
        logic               overflow;
        logic [OutPosW-1:0] match_final;
        logic [OutPosW-1:0] match_first;
        logic [7:0]         literal_value;
        logic               token_kind;
    } glz_tok_t;

    localparam logic KIND_LITERAL = 1'b0;
    localparam logic KIND_MATCH   = 1'b1;

endpackage

// File: src/glzme_ram.sv
// ---------------------------------------------------------------------------
// glzme_ram
// single port write, single port registered read memory
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module glzme_ram #(
    parameter int Width = 8,
    parameter int Depth = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: src/glzme_datapath.sv
// ---------------------------------------------------------------------------
// glzme_datapath
// history memory, stream registers and a two entry token queue
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module glzme_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  glzme_pkg::glz_cmd_t cmd,
    output glzme_pkg::glz_stat_t stat,
    input  logic [7:0]          in_byte,
    input  logic                in_eos,
    output glzme_pkg::glz_tok_t tok_out
);
    import glzme_pkg::*;

    logic [PosW-1:0]  pos_reg, pos_next;
    logic             open_reg, open_next;
    logic [AddrW-1:0] start_reg, start_next;
    logic [AddrW-1:0] end_reg, end_next;
    logic [AddrW-1:0] budget_reg, budget_next;
    logic [7:0]       byte_reg;
    logic             eos_reg;
    logic [AddrW-1:0] scan_reg, scan_next;
    glz_tok_t         q_reg [2];
    glz_tok_t         q_next [2];
    logic [1:0]       cnt_reg, cnt_next;

    logic             we;
    logic [AddrW-1:0] raddr;
    logic [7:0]       rdata;
    logic [AddrW:0]   nx;
    glz_tok_t         t_close, t_lit;
    logic             push_a, push_b;
    glz_tok_t         ta, tb;

    glzme_ram #(.Width(8), .Depth(MaxLen)) u_hist (
        .aclk (aclk),
        .we   (we),
        .waddr(pos_reg[AddrW-1:0]),
        .wdata(byte_reg),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign nx = {1'b0, end_reg} + 1'b1;
    assign we = cmd.do_ext_hit | cmd.do_literal | cmd.do_open;
    assign raddr = cmd.ext_read ? nx[AddrW-1:0] : scan_next;

    always_comb begin
        stat.at_cap      = pos_reg == PosW'(MaxLen);
        stat.match_open  = open_reg;
        stat.ext_ok      = (PosW'(nx) < pos_reg) && !nx[AddrW];
        stat.ext_hit     = rdata == byte_reg;
        stat.scan_hit    = rdata == byte_reg;
        stat.scan_end    = {1'b0, scan_reg} >= pos_reg;
        stat.budget_last = budget_reg <= AddrW'(1);
        stat.open_zero   = pos_reg == PosW'(1);
        stat.eos         = eos_reg;
        stat.q_empty     = cnt_reg == 2'd0;
    end

    always_comb begin
        t_close = '0;
        t_close.token_kind  = KIND_MATCH;
        t_close.match_first = OutPosW'(start_next);
        t_close.match_final = OutPosW'(end_next);
        t_lit = '0;
        t_lit.token_kind    = KIND_LITERAL;
        t_lit.literal_value = byte_reg;
        t_lit.overflow      = cmd.do_ovf;
    end

    always_comb begin
        pos_next    = pos_reg;
        open_next   = open_reg;
        start_next  = start_reg;
        end_next    = end_reg;
        budget_next = budget_reg;
        scan_next   = scan_reg;
        if (cmd.scan_start) begin
            scan_next = '0;
        end else if (cmd.scan_step) begin
            scan_next = scan_reg + 1'b1;
        end
        if (cmd.do_ext_hit) begin
            pos_next = pos_reg + 1'b1;
            end_next = nx[AddrW-1:0];
            if (budget_reg != '0) begin
                budget_next = budget_reg - 1'b1;
            end
        end
        if (cmd.do_literal) begin
            pos_next = pos_reg + 1'b1;
        end
        if (cmd.do_open) begin
            pos_next    = pos_reg + 1'b1;
            open_next   = 1'b1;
            start_next  = scan_reg;
            end_next    = scan_reg;
            budget_next = AddrW'(pos_reg - 1'b1);
        end
        if (cmd.do_close) begin
            open_next = 1'b0;
        end
    end

    // queue order: a close token goes first, a literal after
    always_comb begin
        push_a = 1'b0;
        push_b = 1'b0;
        ta = t_close;
        tb = t_lit;
        if (cmd.do_close) begin
            push_a = 1'b1;
            ta = t_close;
            if (cmd.do_literal || cmd.do_ovf) begin
                push_b = 1'b1;
            end
        end else if (cmd.do_literal || cmd.do_ovf) begin
            push_a = 1'b1;
            ta = t_lit;
        end
        q_next = q_reg;
        cnt_next = cnt_reg;
        if (cmd.out_pop) begin
            q_next[0] = q_reg[1];
            cnt_next  = cnt_reg - 1'b1;
        end
        // tokens of one byte may be queued over several cycles
        if (push_a) begin
            if (cnt_reg == 2'd0) begin
                q_next[0] = ta;
                q_next[1] = tb;
            end else begin
                q_next[1] = ta;
            end
            cnt_next = cnt_reg + (push_b ? 2'd2 : 2'd1);
        end
    end

    // tokens drain only after the byte is done, so the last one is the one left alone
    always_comb begin
        tok_out = q_reg[0];
        tok_out.last_token = cnt_reg == 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            byte_reg <= in_byte;
            eos_reg  <= in_eos;
        end
        q_reg    <= q_next;
        scan_reg <= scan_next;
        if (!aresetn) begin
            pos_reg    <= '0;
            open_reg   <= 1'b0;
            start_reg  <= '0;
            end_reg    <= '0;
            budget_reg <= '0;
            cnt_reg    <= '0;
        end else if (cmd.do_eos) begin
            pos_reg    <= '0;
            open_reg   <= 1'b0;
            start_reg  <= '0;
            end_reg    <= '0;
            budget_reg <= '0;
            cnt_reg    <= cnt_next;
        end else begin
            pos_reg    <= pos_next;
            open_reg   <= open_next;
            start_reg  <= start_next;
            end_reg    <= end_next;
            budget_reg <= budget_next;
            cnt_reg    <= cnt_next;
        end
    end
endmodule

// File: src/glzme_ctrl.sv
// ---------------------------------------------------------------------------
// glzme_ctrl
// sequencer: extension check, serial history search, token drain
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module glzme_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  glzme_pkg::glz_stat_t stat,
    output glzme_pkg::glz_cmd_t  cmd
);
    import glzme_pkg::*;

    glz_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                priority if (stat.at_cap) begin
                    state_next = ST_EMIT;
                end else if (stat.match_open && stat.ext_ok) begin
                    state_next = ST_EXT_WAIT;
                end else begin
                    state_next = ST_SCAN_WAIT;
                end
            end
            ST_EXT_WAIT: begin
                if (stat.ext_hit) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_SCAN_WAIT;
                end
            end
            ST_SCAN_WAIT: state_next = ST_SCAN;
            ST_SCAN: begin
                if (stat.scan_end || stat.scan_hit) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.q_empty) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            ST_CLEAR: begin
                cmd.scan_start = 1'b1;
                cmd.ext_read   = stat.match_open && stat.ext_ok && !stat.at_cap;
                if (stat.at_cap) begin
                    cmd.do_ovf   = 1'b1;
                    cmd.do_close = stat.match_open;
                    cmd.do_eos   = stat.eos;
                end else if (stat.match_open && !stat.ext_ok) begin
                    cmd.do_close = 1'b1;
                end
            end
            ST_EXT_WAIT: begin
                if (stat.ext_hit) begin
                    cmd.do_ext_hit = 1'b1;
                    cmd.do_close   = stat.budget_last || stat.eos;
                    cmd.do_eos     = stat.eos;
                end else begin
                    cmd.do_close = 1'b1;
                end
            end
            // address zero is read here, compared in the first scan cycle
            ST_SCAN_WAIT: ;
            ST_SCAN: begin
                if (stat.scan_end) begin
                    cmd.do_literal = 1'b1;
                    cmd.do_eos     = stat.eos;
                end else if (stat.scan_hit) begin
                    cmd.do_open  = 1'b1;
                    cmd.do_close = stat.open_zero || stat.eos;
                    cmd.do_eos   = stat.eos;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_EMIT: begin
                out_valid   = !stat.q_empty;
                cmd.out_pop = out_ready && !stat.q_empty;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

// File: src/greedy_lz_match_encoder.sv
// ---------------------------------------------------------------------------
// greedy_lz_match_encoder
// greedy lz encoder over a byte stream with a 1024 byte history
// ---------------------------------------------------------------------------
// One byte is taken at a time. A byte that extends an open run passes
// through the clear, extension wait and emit states; any other byte
// searches the history serially, one memory read per cycle from position
// zero up to a hit or to the stream position p (after a failed extension
// it first passes the extension wait), and a byte past the history goes
// from clear straight to emit. The search loop over the single-read
// history memory sets the time per byte. Up to two tokens leave per byte,
// a closing match first, and the last one carries m_axis_tlast.
`timescale 1ns / 1ps

module greedy_lz_match_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tlast,   // end_of_stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // literal_value, match_first, match_final, zeros
    output logic [1:0]  m_axis_tuser,   // token_kind, overflow
    output logic        m_axis_tlast    // last_token
);
    import glzme_pkg::*;

    glz_cmd_t  cmd;
    glz_stat_t stat;
    glz_tok_t  tok;

    glzme_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    glzme_datapath u_dp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cmd    (cmd),
        .stat   (stat),
        .in_byte(s_axis_tdata),
        .in_eos (s_axis_tlast),
        .tok_out(tok)
    );

    assign m_axis_tdata = {4'd0, tok.match_final, tok.match_first, tok.literal_value};
    assign m_axis_tuser = {tok.overflow, tok.token_kind};
    assign m_axis_tlast = tok.last_token;
endmodule

// File: src/glzme_checker.sv
// ---------------------------------------------------------------------------
// glzme_checker
// port level checks of the greedy lz match encoder
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "greedy_lz_match_encoder_assert.svh"

module glzme_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    // one byte at a time: no input while results are shown
    `GLZ_ASSERT_IMP(a_no_overlap, m_axis_tvalid, !s_axis_tready)
    // a literal carries no match positions
    `GLZ_ASSERT_IMP(a_lit_clean, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[31:8] == 24'd0)
    // a match carries no byte and never overflow
    `GLZ_ASSERT_IMP(a_match_clean, m_axis_tvalid && m_axis_tuser[0],
        m_axis_tdata[7:0] == 8'd0 && !m_axis_tuser[1])
    // a stalled beat holds
    `GLZ_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
endmodule

bind greedy_lz_match_encoder glzme_checker u_chk (.*);
